FILE: hw/rtl/arc_pkg.sv
// Shared types and constants for the ARP receive cache engine.
package arc_pkg;

  localparam int unsigned CacheEntries = 32;

  localparam int unsigned MacW  = 48;
  localparam int unsigned IpW   = 32;
  localparam int unsigned KindW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] RegOwnIp      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOwnMac     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLinkType   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegProtocol   = 3'd3;

  localparam logic [KindW-1:0] LinkTypeReset = 16'h0001;
  localparam logic [KindW-1:0] ProtocolReset = 16'h0800;

  localparam logic [1:0] OutBadLink  = 2'd0;
  localparam logic [1:0] OutBadProto = 2'd1;
  localparam logic [1:0] OutNotUs    = 2'd2;
  localparam logic [1:0] OutForUs    = 2'd3;

  localparam logic [1:0] ActNone    = 2'd0;
  localparam logic [1:0] ActRefresh = 2'd1;
  localparam logic [1:0] ActInsert  = 2'd2;
  localparam logic [1:0] ActFull    = 2'd3;

  localparam logic [KindW-1:0] OpRequest = 16'd1;
  localparam logic [KindW-1:0] OpReply   = 16'd2;

  // one classified item as it travels through the queue
  typedef struct packed {
    logic [1:0]       outcome;
    logic [MacW-1:0]  fsrc;
    logic [KindW-1:0] link;
    logic [KindW-1:0] proto;
    logic [KindW-1:0] op;
    logic [MacW-1:0]  smac;
    logic [IpW-1:0]   sip;
  } item_t;

  // station identity used to build replies
  typedef struct packed {
    logic [IpW-1:0]  own_ip;
    logic [MacW-1:0] own_mac;
  } station_t;

  // queue handshake between front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

FILE: hw/rtl/arc_front.sv
// Front end: configuration registers, item acceptance and classification.
module arc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [arc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [arc_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              start_i,
  input  logic                              q_full_i,
  input  logic [arc_pkg::MacW-1:0]          frame_source_mac_i,
  input  logic [arc_pkg::KindW-1:0]         link_kind_i,
  input  logic [arc_pkg::KindW-1:0]         protocol_kind_i,
  input  logic [arc_pkg::KindW-1:0]         op_code_i,
  input  logic [arc_pkg::MacW-1:0]          sender_mac_i,
  input  logic [arc_pkg::IpW-1:0]           sender_ip_i,
  input  logic [arc_pkg::IpW-1:0]           target_ip_i,
  output logic                              push_o,
  output arc_pkg::item_t                    item_o,
  output arc_pkg::station_t                 station_o
);

  logic [arc_pkg::IpW-1:0]   own_ip_q;
  logic [arc_pkg::MacW-1:0]  own_mac_q;
  logic [arc_pkg::KindW-1:0] link_type_q;
  logic [arc_pkg::KindW-1:0] protocol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q    <= '0;
      own_mac_q   <= '0;
      link_type_q <= arc_pkg::LinkTypeReset;
      protocol_q  <= arc_pkg::ProtocolReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        arc_pkg::RegOwnIp:    own_ip_q    <= cfg_data_i[arc_pkg::IpW-1:0];
        arc_pkg::RegOwnMac:   own_mac_q   <= cfg_data_i[arc_pkg::MacW-1:0];
        arc_pkg::RegLinkType: link_type_q <= cfg_data_i[arc_pkg::KindW-1:0];
        arc_pkg::RegProtocol: protocol_q  <= cfg_data_i[arc_pkg::KindW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item_o.fsrc  = frame_source_mac_i;
    item_o.link  = link_kind_i;
    item_o.proto = protocol_kind_i;
    item_o.op    = op_code_i;
    item_o.smac  = sender_mac_i;
    item_o.sip   = sender_ip_i;
    if (link_kind_i != link_type_q) begin
      item_o.outcome = arc_pkg::OutBadLink;
    end else if (protocol_kind_i != protocol_q) begin
      item_o.outcome = arc_pkg::OutBadProto;
    end else if (target_ip_i == own_ip_q) begin
      item_o.outcome = arc_pkg::OutForUs;
    end else begin
      item_o.outcome = arc_pkg::OutNotUs;
    end
  end

  assign push_o            = start_i && !q_full_i;
  assign station_o.own_ip  = own_ip_q;
  assign station_o.own_mac = own_mac_q;

endmodule

FILE: hw/rtl/arc_queue.sv
// Short item queue between the front and back ends.
module arc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  arc_pkg::item_t      item_i,
  input  logic                pop_i,
  output arc_pkg::item_t      item_o,
  output arc_pkg::q_status_t  status_o
);

  localparam int unsigned PtrW = $clog2(arc_pkg::QueueDepth);

  arc_pkg::item_t      mem_q [arc_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign item_o         = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == (PtrW+1)'(arc_pkg::QueueDepth));

endmodule

FILE: hw/rtl/arc_back.sv
// Back end: cache scan, refresh or insert, and result generation.
module arc_back #(
  parameter int unsigned CACHE_ENTRIES = arc_pkg::CacheEntries
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  arc_pkg::q_status_t         q_status_i,
  input  arc_pkg::item_t             item_i,
  input  arc_pkg::station_t          station_i,
  output logic                       pop_o,
  output logic                       done_o,
  output logic [1:0]                 outcome_o,
  output logic [1:0]                 table_action_o,
  output logic                       reply_valid_o,
  output logic [arc_pkg::MacW-1:0]   reply_frame_dest_o,
  output logic [arc_pkg::MacW-1:0]   reply_frame_src_o,
  output logic [arc_pkg::MacW-1:0]   reply_target_mac_o,
  output logic [arc_pkg::IpW-1:0]    reply_target_ip_o,
  output logic [arc_pkg::MacW-1:0]   reply_sender_mac_o,
  output logic [arc_pkg::IpW-1:0]    reply_sender_ip_o,
  output logic [arc_pkg::KindW-1:0]  reply_op_o,
  output logic [arc_pkg::KindW-1:0]  reply_link_kind_o,
  output logic [arc_pkg::KindW-1:0]  reply_protocol_kind_o
);

  localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CACHE_ENTRIES - 1);
  localparam int unsigned TagW = arc_pkg::KindW + arc_pkg::IpW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  state_e                    state_q;
  arc_pkg::item_t            item_q;
  logic [CACHE_ENTRIES-1:0]  used_q;
  logic [IdxW-1:0]           scan_idx_q, cmp_idx_q, hit_idx_q, free_idx_q;
  logic                      scan_last_q, cmp_vld_q, hit_q, free_found_q;
  logic [TagW-1:0]           tag_rd_q;

  logic [TagW-1:0]           tag_mem [CACHE_ENTRIES];
  logic [arc_pkg::MacW-1:0]  mac_mem [CACHE_ENTRIES];

  logic                      for_us, tag_we, mac_we, cmp_hit, is_reply;
  logic [IdxW-1:0]           mac_wa;

  assign for_us   = (item_q.outcome == arc_pkg::OutForUs);
  assign is_reply = for_us && (item_q.op == arc_pkg::OpRequest);
  assign tag_we   = (state_q == S_DECIDE) && !hit_q && for_us && free_found_q;
  assign mac_we   = tag_we || ((state_q == S_DECIDE) && hit_q);
  assign mac_wa   = hit_q ? hit_idx_q : free_idx_q;
  assign cmp_hit  = cmp_vld_q && used_q[cmp_idx_q] && (tag_rd_q == {item_q.link, item_q.sip});
  assign pop_o    = (state_q == S_IDLE) && !q_status_i.empty;

  always_ff @(posedge clk_i) begin
    tag_rd_q <= tag_mem[scan_idx_q];
    if (tag_we) begin
      tag_mem[free_idx_q] <= {item_q.link, item_q.sip};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_we) begin
      mac_mem[mac_wa] <= item_q.smac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q               <= S_IDLE;
      item_q                <= '0;
      used_q                <= '0;
      scan_idx_q            <= '0;
      cmp_idx_q             <= '0;
      hit_idx_q             <= '0;
      free_idx_q            <= '0;
      done_o                <= 1'b0;
      scan_last_q           <= 1'b0;
      cmp_vld_q             <= 1'b0;
      hit_q                 <= 1'b0;
      free_found_q          <= 1'b0;
      outcome_o             <= '0;
      table_action_o        <= '0;
      reply_valid_o         <= 1'b0;
      reply_frame_dest_o    <= '0;
      reply_frame_src_o     <= '0;
      reply_target_mac_o    <= '0;
      reply_target_ip_o     <= '0;
      reply_sender_mac_o    <= '0;
      reply_sender_ip_o     <= '0;
      reply_op_o            <= '0;
      reply_link_kind_o     <= '0;
      reply_protocol_kind_o <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            item_q       <= item_i;
            scan_idx_q   <= '0;
            scan_last_q  <= 1'b0;
            cmp_vld_q    <= 1'b0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            if (item_i.outcome == arc_pkg::OutBadLink ||
                item_i.outcome == arc_pkg::OutBadProto) begin
              done_o                <= 1'b1;
              outcome_o             <= item_i.outcome;
              table_action_o        <= arc_pkg::ActNone;
              reply_valid_o         <= 1'b0;
              reply_frame_dest_o    <= '0;
              reply_frame_src_o     <= '0;
              reply_target_mac_o    <= '0;
              reply_target_ip_o     <= '0;
              reply_sender_mac_o    <= '0;
              reply_sender_ip_o     <= '0;
              reply_op_o            <= '0;
              reply_link_kind_o     <= '0;
              reply_protocol_kind_o <= '0;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_vld_q <= !scan_last_q;
          cmp_idx_q <= scan_idx_q;
          if (!scan_last_q) begin
            if (!free_found_q && !used_q[scan_idx_q]) begin
              free_found_q <= 1'b1;
              free_idx_q   <= scan_idx_q;
            end
            if (scan_idx_q == LastIdx) begin
              scan_last_q <= 1'b1;
            end else begin
              scan_idx_q <= scan_idx_q + 1'b1;
            end
          end
          if (cmp_hit) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cmp_idx_q;
            state_q   <= S_DECIDE;
          end else if (cmp_vld_q && cmp_idx_q == LastIdx) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          done_o    <= 1'b1;
          outcome_o <= item_q.outcome;
          if (hit_q) begin
            table_action_o <= arc_pkg::ActRefresh;
          end else if (!for_us) begin
            table_action_o <= arc_pkg::ActNone;
          end else if (free_found_q) begin
            table_action_o     <= arc_pkg::ActInsert;
            used_q[free_idx_q] <= 1'b1;
          end else begin
            table_action_o <= arc_pkg::ActFull;
          end
          reply_valid_o         <= is_reply;
          reply_frame_dest_o    <= is_reply ? item_q.fsrc : '0;
          reply_frame_src_o     <= is_reply ? station_i.own_mac : '0;
          reply_target_mac_o    <= is_reply ? item_q.smac : '0;
          reply_target_ip_o     <= is_reply ? item_q.sip : '0;
          reply_sender_mac_o    <= is_reply ? station_i.own_mac : '0;
          reply_sender_ip_o     <= is_reply ? station_i.own_ip : '0;
          reply_op_o            <= is_reply ? arc_pkg::OpReply : '0;
          reply_link_kind_o     <= is_reply ? item_q.link : '0;
          reply_protocol_kind_o <= is_reply ? item_q.proto : '0;
          state_q               <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/arp_receive_cache_engine_core.sv
// Top level of the ARP receive cache engine.
// An item is taken when start_i is high and busy_o is low; busy_o rises only
// when the two-entry queue behind the classifier is full. Each item yields
// exactly one result, shown for one cycle with done_o high; the receiver
// cannot stall it. A dropped packet (bad hardware or protocol type) gives its
// result from the idle state of the back end without a cache scan; any other
// packet scans the cache one entry per cycle through the single read port of
// the tag memory and stops early when a matching entry is found. The cache
// valid bits clear at reset, so no clearing pass is needed.
module arp_receive_cache_engine_core #(
  parameter int unsigned CACHE_ENTRIES = arc_pkg::CacheEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [arc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [arc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [arc_pkg::MacW-1:0]      frame_source_mac_i,
  input  logic [arc_pkg::KindW-1:0]     link_kind_i,
  input  logic [arc_pkg::KindW-1:0]     protocol_kind_i,
  input  logic [arc_pkg::KindW-1:0]     op_code_i,
  input  logic [arc_pkg::MacW-1:0]      sender_mac_i,
  input  logic [arc_pkg::IpW-1:0]       sender_ip_i,
  input  logic [arc_pkg::IpW-1:0]       target_ip_i,
  output logic                          done_o,
  output logic [1:0]                    outcome_o,
  output logic [1:0]                    table_action_o,
  output logic                          reply_valid_o,
  output logic [arc_pkg::MacW-1:0]      reply_frame_dest_o,
  output logic [arc_pkg::MacW-1:0]      reply_frame_src_o,
  output logic [arc_pkg::MacW-1:0]      reply_target_mac_o,
  output logic [arc_pkg::IpW-1:0]       reply_target_ip_o,
  output logic [arc_pkg::MacW-1:0]      reply_sender_mac_o,
  output logic [arc_pkg::IpW-1:0]       reply_sender_ip_o,
  output logic [arc_pkg::KindW-1:0]     reply_op_o,
  output logic [arc_pkg::KindW-1:0]     reply_link_kind_o,
  output logic [arc_pkg::KindW-1:0]     reply_protocol_kind_o
);

  logic               push, pop;
  arc_pkg::item_t     front_item, back_item;
  arc_pkg::station_t  station;
  arc_pkg::q_status_t q_status;

  assign busy_o = q_status.full;

  arc_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .start_i,
    .q_full_i (q_status.full),
    .frame_source_mac_i,
    .link_kind_i,
    .protocol_kind_i,
    .op_code_i,
    .sender_mac_i,
    .sender_ip_i,
    .target_ip_i,
    .push_o   (push),
    .item_o   (front_item),
    .station_o(station)
  );

  arc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (back_item),
    .status_o(q_status)
  );

  arc_back #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_status_i(q_status),
    .item_i    (back_item),
    .station_i (station),
    .pop_o     (pop),
    .done_o,
    .outcome_o,
    .table_action_o,
    .reply_valid_o,
    .reply_frame_dest_o,
    .reply_frame_src_o,
    .reply_target_mac_o,
    .reply_target_ip_o,
    .reply_sender_mac_o,
    .reply_sender_ip_o,
    .reply_op_o,
    .reply_link_kind_o,
    .reply_protocol_kind_o
  );

endmodule

FILE: hw/rtl/arc_checker.sv
// Port-level checks for the ARP receive cache engine, bound to the top level.
module arc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          done_o,
  input logic [1:0]                    outcome_o,
  input logic [1:0]                    table_action_o,
  input logic                          reply_valid_o,
  input logic [arc_pkg::MacW-1:0]      reply_frame_src_o,
  input logic [arc_pkg::MacW-1:0]      reply_sender_mac_o,
  input logic [arc_pkg::KindW-1:0]     reply_op_o
);

  a_reply_for_us: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && reply_valid_o |-> outcome_o == arc_pkg::OutForUs)
    else $error("reply on an item not aimed at this station");

  a_drop_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (outcome_o == arc_pkg::OutBadLink || outcome_o == arc_pkg::OutBadProto)
    |-> table_action_o == arc_pkg::ActNone)
    else $error("dropped item touched the cache");

  a_not_us_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && outcome_o == arc_pkg::OutNotUs
    |-> table_action_o == arc_pkg::ActNone || table_action_o == arc_pkg::ActRefresh)
    else $error("item for another host inserted into the cache");

  a_reply_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && reply_valid_o
    |-> reply_op_o == arc_pkg::OpReply && reply_sender_mac_o == reply_frame_src_o)
    else $error("reply fields inconsistent");

  a_no_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !reply_valid_o |-> reply_op_o == '0)
    else $error("reply opcode set without a reply");

endmodule

bind arp_receive_cache_engine_core arc_checker u_arc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .done_o            (done_o),
  .outcome_o         (outcome_o),
  .table_action_o    (table_action_o),
  .reply_valid_o     (reply_valid_o),
  .reply_frame_src_o (reply_frame_src_o),
  .reply_sender_mac_o(reply_sender_mac_o),
  .reply_op_o        (reply_op_o)
);
